### src/playfair_digram_cipher_assert.svh
// ----------------------------------------------------------------------------
// playfair digram cipher assertion macros
// concurrent assertion wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAM_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAM_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every rising edge, disabled while reset is high
`define PDC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pdc assertion failed");

// property checked on every rising edge, reset included
`define PDC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pdc assertion failed");

`else

`define PDC_ASSERT(label, clk, rst, prop)
`define PDC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### src/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// shared types, constants and helper functions of the playfair digram cipher
// ----------------------------------------------------------------------------
package pdc_pkg;

  // character codes and symbol table
  localparam int CODE_W  = 6;
  localparam int SYMBOLS = 64;
  localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  // square geometry
  localparam int CELLS  = 25;
  localparam int SIDE   = 5;
  localparam int CELL_W = 5;
  localparam int RC_W   = 3;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_I = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_J = 1'b1;

  // operation codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_KEY    = 2'd1,
    CMD_FILL   = 2'd2,
    CMD_ENCODE = 2'd3
  } cmd_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic look;
    logic commit;
  } ctl_t;

  // j folds into i only when both exist and differ
  function automatic logic is_folded_j(input logic [CODE_W-1:0] c,
                                       input logic [CODE_W-1:0] i_code,
                                       input logic [CODE_W-1:0] j_code);
    return (i_code != '0) && (j_code != '0) && (i_code != j_code) &&
           (c == j_code);
  endfunction

  function automatic logic [CODE_W-1:0] fold_code(input logic [CODE_W-1:0] c,
                                                  input logic [CODE_W-1:0] i_code,
                                                  input logic [CODE_W-1:0] j_code);
    return is_folded_j(c, i_code, j_code) ? i_code : c;
  endfunction

  function automatic logic in_range(input logic [CODE_W-1:0] c);
    return (32'(c) < SYMBOLS);
  endfunction

  function automatic logic [SYM_W-1:0] sym_idx(input logic [CODE_W-1:0] c);
    return SYM_W'(c);
  endfunction

  // row of a cell index below 25
  function automatic logic [RC_W-1:0] row_of(input logic [CELL_W-1:0] p);
    logic [RC_W-1:0] r;
    r = '0;
    if (p >= CELL_W'(SIDE))     r = RC_W'(1);
    if (p >= CELL_W'(2 * SIDE)) r = RC_W'(2);
    if (p >= CELL_W'(3 * SIDE)) r = RC_W'(3);
    if (p >= CELL_W'(4 * SIDE)) r = RC_W'(4);
    return r;
  endfunction

  function automatic logic [RC_W-1:0] col_of(input logic [CELL_W-1:0] p);
    logic [RC_W-1:0] r;
    r = row_of(p);
    return RC_W'(p - CELL_W'(r) * CELL_W'(SIDE));
  endfunction

  function automatic logic [RC_W-1:0] wrap_inc(input logic [RC_W-1:0] v);
    return (v == RC_W'(SIDE - 1)) ? '0 : RC_W'(v + RC_W'(1));
  endfunction

  function automatic logic [CELL_W-1:0] cell_at(input logic [RC_W-1:0] r,
                                                input logic [RC_W-1:0] c);
    return CELL_W'(CELL_W'(r) * CELL_W'(SIDE) + CELL_W'(c));
  endfunction

endpackage

### src/pdc_ram.sv
// ----------------------------------------------------------------------------
// pdc_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### src/pdc_ctrl.sv
// ----------------------------------------------------------------------------
// pdc_ctrl
// sequencer: accept a word, look up positions, commit and fill the output slot
// ----------------------------------------------------------------------------
`include "playfair_digram_cipher_assert.svh"

module pdc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output pdc_pkg::ctl_t ctl
);

  import pdc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_FIN
  } state_t;

  state_t state;

  // handshake and commands
  assign in_stall   = (state != S_IDLE);
  assign ctl.accept = (state == S_IDLE) && in_valid;
  assign ctl.look   = (state == S_LOOK);
  assign ctl.commit = (state == S_FIN) && (!out_valid || !out_stall);

  // state and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_LOOK;
        end
        S_LOOK: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (ctl.commit) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PDC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE) && !out_valid)
  `PDC_ASSERT(a_accept_look, clk, rst, ctl.accept |=> ctl.look)
  `PDC_ASSERT(a_commit_out, clk, rst, ctl.commit |=> out_valid)
  `PDC_ASSERT(a_fin_from_look, clk, rst,
    (state == S_FIN) |-> ($past(state) == S_LOOK) || ($past(state) == S_FIN))

endmodule

### src/pdc_dpath.sv
// ----------------------------------------------------------------------------
// pdc_dpath
// square storage, position lookup, cipher rules and output register
// ----------------------------------------------------------------------------
`include "playfair_digram_cipher_assert.svh"

module pdc_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pdc_pkg::ctl_t                        ctl,
  input  logic                                 cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pdc_pkg::CODE_W-1:0]           cfg_data,
  input  logic [1:0]                           cmd,
  input  logic [pdc_pkg::CODE_W-1:0]           first_char,
  input  logic [pdc_pkg::CODE_W-1:0]           second_char,
  input  logic                                 has_second,
  output logic [pdc_pkg::CODE_W-1:0]           out_first,
  output logic [pdc_pkg::CODE_W-1:0]           out_second,
  output logic                                 enciphered,
  output logic                                 placed
);

  import pdc_pkg::*;

  // configuration registers
  logic [CODE_W-1:0] letter_i_code;
  logic [CODE_W-1:0] letter_j_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_i_code <= '0;
      letter_j_code <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_LETTER_I) letter_i_code <= cfg_data;
      if (cfg_index == REG_LETTER_J) letter_j_code <= cfg_data;
    end
  end

  // captured word
  cmd_t              cmd_r;
  logic [CODE_W-1:0] a_r;
  logic [CODE_W-1:0] b_r;
  logic              pair_r;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r  <= cmd_t'(cmd);
      a_r    <= first_char;
      b_r    <= second_char;
      pair_r <= has_second;
    end
  end

  // square state: presence flags and fill count
  logic [SYMBOLS-1:0] present;
  logic [CELL_W-1:0]  fill_count;

  // folded codes of the captured word
  logic [CODE_W-1:0] a_f;
  logic [CODE_W-1:0] b_f;
  assign a_f = fold_code(a_r, letter_i_code, letter_j_code);
  assign b_f = fold_code(b_r, letter_i_code, letter_j_code);

  // placement decision
  logic [CODE_W-1:0] place_code;
  logic              place_cmd;
  logic              place_ok;
  logic              do_place;
  logic              do_clear;

  assign place_code = (cmd_r == CMD_KEY) ? a_f : a_r;
  assign place_cmd  = (cmd_r == CMD_KEY) ||
                      ((cmd_r == CMD_FILL) &&
                       !is_folded_j(a_r, letter_i_code, letter_j_code));
  assign place_ok   = place_cmd && (place_code != '0) && in_range(place_code) &&
                      (fill_count < CELL_W'(CELLS)) &&
                      !present[sym_idx(place_code)];
  assign do_place   = ctl.commit && place_ok;
  assign do_clear   = ctl.commit && (cmd_r == CMD_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      fill_count <= '0;
    end else if (do_clear) begin
      present    <= '0;
      fill_count <= '0;
    end else if (do_place) begin
      present[sym_idx(place_code)] <= 1'b1;
      fill_count                   <= CELL_W'(fill_count + CELL_W'(1));
    end
  end

  // position memory, read at accept with the incoming folded codes
  logic [CELL_W-1:0] pos_a;
  logic [CELL_W-1:0] pos_b;

  pdc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (SYMBOLS)
  ) u_pos_ram (
    .clk     (clk),
    .we      (do_place),
    .waddr   (sym_idx(place_code)),
    .wdata   (fill_count),
    .raddr_a (sym_idx(fold_code(first_char, letter_i_code, letter_j_code))),
    .raddr_b (sym_idx(fold_code(second_char, letter_i_code, letter_j_code))),
    .rdata_a (pos_a),
    .rdata_b (pos_b)
  );

  // cipher rules on the looked-up positions
  logic              found_a;
  logic              found_b;
  logic [RC_W-1:0]   r0, c0, r1, c1;
  logic [CELL_W-1:0] t0, t1;
  logic              pair_ok;

  assign found_a = (a_f != '0) && in_range(a_f) && present[sym_idx(a_f)];
  assign found_b = (b_f != '0) && in_range(b_f) && present[sym_idx(b_f)];
  assign r0 = row_of(pos_a);
  assign c0 = col_of(pos_a);
  assign r1 = row_of(pos_b);
  assign c1 = col_of(pos_b);
  assign pair_ok = pair_r && found_a && found_b && (pos_a != pos_b);

  always_comb begin
    if (r0 == r1) begin
      t0 = cell_at(r0, wrap_inc(c0));
      t1 = cell_at(r1, wrap_inc(c1));
    end else if (c0 == c1) begin
      t0 = cell_at(wrap_inc(r0), c0);
      t1 = cell_at(wrap_inc(r1), c1);
    end else begin
      t0 = cell_at(r0, c1);
      t1 = cell_at(r1, c0);
    end
  end

  // targets and verdict held through the commit state
  logic [CELL_W-1:0] t0_r;
  logic [CELL_W-1:0] t1_r;
  logic              enc_ok;

  always_ff @(posedge clk) begin
    if (ctl.look) begin
      t0_r   <= t0;
      t1_r   <= t1;
      enc_ok <= pair_ok && (t0 < fill_count) && (t1 < fill_count);
    end
  end

  // square cell memory, cells below fill_count hold valid characters
  logic [CODE_W-1:0] cell_a;
  logic [CODE_W-1:0] cell_b;

  pdc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .we      (do_place),
    .waddr   (fill_count),
    .wdata   (place_code),
    .raddr_a (ctl.look ? t0 : t0_r),
    .raddr_b (ctl.look ? t1 : t1_r),
    .rdata_a (cell_a),
    .rdata_b (cell_b)
  );

  // output register
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      case (cmd_r)
        CMD_ENCODE: begin
          out_first  <= enc_ok ? cell_a : a_r;
          out_second <= enc_ok ? cell_b : (pair_r ? b_r : '0);
          enciphered <= enc_ok;
          placed     <= 1'b0;
        end
        default: begin
          out_first  <= '0;
          out_second <= '0;
          enciphered <= 1'b0;
          placed     <= place_ok;
        end
      endcase
    end
  end

  `PDC_ASSERT(a_fill_max, clk, rst, fill_count <= CELL_W'(CELLS))
  `PDC_ASSERT(a_fill_step, clk, rst,
    do_place && !do_clear |=> fill_count == CELL_W'($past(fill_count) + CELL_W'(1)))

endmodule

### src/playfair_digram_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digram_cipher
// builds a 5x5 playfair square from keyword and fill characters and
// enciphers letter pairs with it
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_stall | cmd, first_char, second_char, has_second
//  out      | out_valid/out_stall | out_first, out_second, enciphered, placed
//  cfg      | cfg_we              | cfg_index, cfg_data
//
//  every word passes through accept, position memory read, and cell memory
//  read with commit; the two registered memory reads lie in series
//  reset clears the square at once through per-symbol presence flags
//  a clear command empties the square in its commit cycle, no sweep
//  a new word is accepted while a result waits in the output register;
//  the commit stalls only while that register is full and stalled
// ----------------------------------------------------------------------------
module playfair_digram_cipher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    cmd,
  input  logic [pdc_pkg::CODE_W-1:0]    first_char,
  input  logic [pdc_pkg::CODE_W-1:0]    second_char,
  input  logic                          has_second,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pdc_pkg::CODE_W-1:0]    out_first,
  output logic [pdc_pkg::CODE_W-1:0]    out_second,
  output logic                          enciphered,
  output logic                          placed,
  input  logic                          cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdc_pkg::CODE_W-1:0]    cfg_data
);

  import pdc_pkg::*;

  ctl_t ctl;

  // sequencer
  pdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // square and cipher datapath
  pdc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .first_char  (first_char),
    .second_char (second_char),
    .has_second  (has_second),
    .out_first   (out_first),
    .out_second  (out_second),
    .enciphered  (enciphered),
    .placed      (placed)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for playfair_digram_cipher: a short table of directed
// words and register writes, some with fixed expected results, then random
// phases that write registers, clear the square, load keyword and fill
// characters and encode pairs or send noise words, checked against a local
// model of the square with random idling and one long output hold-off
module tb_top;
  import pdc_pkg::*;

  localparam int ITEMS       = 1800;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN       = 8;
  localparam int HOLD_CYCLES = 60;
  localparam int NSET        = 8;

  localparam logic CHK  = 1'b1;
  localparam logic PRED = 1'b0;

  typedef struct packed {
    cmd_t              op;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    logic              pair;
  } word_t;

  typedef struct packed {
    logic [CODE_W-1:0] o1;
    logic [CODE_W-1:0] o2;
    logic              enc;
    logic              plc;
  } result_t;

  // one row of the directed table: a register write or a word
  typedef struct packed {
    logic                 wr;
    logic [CFG_IDX_W-1:0] ridx;
    logic [CODE_W-1:0]    rval;
    cmd_t                 op;
    logic [CODE_W-1:0]    a;
    logic [CODE_W-1:0]    b;
    logic                 pair;
    logic                 typed;
    logic [CODE_W-1:0]    o1;
    logic [CODE_W-1:0]    o2;
    logic                 enc;
    logic                 plc;
  } step_t;

  localparam int NDIR = 31;
  localparam step_t DIRECTED [NDIR] = '{
    // empty square after reset, lone trailing character
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 1, 2, 1, CHK, 1, 2, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 63, 5, 0, CHK, 63, 0, 0, 0},
    // zero code ignored, duplicate ignored
    '{0, REG_LETTER_I, 0, CMD_KEY, 0, 0, 0, CHK, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_KEY, 63, 0, 0, CHK, 0, 0, 0, 1},
    '{0, REG_LETTER_I, 0, CMD_KEY, 63, 0, 0, CHK, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_FILL, 1, 0, 0, CHK, 0, 0, 0, 1},
    // empty target cell, zero letter, both letters in one cell
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 63, 1, 1, CHK, 63, 1, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 0, 63, 1, CHK, 0, 63, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 63, 63, 1, CHK, 63, 63, 0, 0},
    // clear, then letters absent
    '{0, REG_LETTER_I, 0, CMD_CLEAR, 63, 63, 1, CHK, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 63, 1, 1, CHK, 63, 1, 0, 0},
    // j folds into i
    '{1, REG_LETTER_I, 9, CMD_CLEAR, 0, 0, 0, PRED, 0, 0, 0, 0},
    '{1, REG_LETTER_J, 10, CMD_CLEAR, 0, 0, 0, PRED, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_KEY, 10, 0, 0, CHK, 0, 0, 0, 1},
    '{0, REG_LETTER_I, 0, CMD_FILL, 10, 0, 0, CHK, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_FILL, 9, 0, 0, CHK, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_FILL, 2, 0, 0, CHK, 0, 0, 0, 1},
    '{0, REG_LETTER_I, 0, CMD_FILL, 3, 0, 0, PRED, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 10, 2, 1, PRED, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 3, 9, 1, PRED, 0, 0, 0, 0},
    // equal i and j codes: no folding
    '{1, REG_LETTER_I, 63, CMD_CLEAR, 0, 0, 0, PRED, 0, 0, 0, 0},
    '{1, REG_LETTER_J, 63, CMD_CLEAR, 0, 0, 0, PRED, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_KEY, 63, 0, 0, PRED, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 10, 2, 1, PRED, 0, 0, 0, 0},
    // i absent
    '{1, REG_LETTER_I, 0, CMD_CLEAR, 0, 0, 0, PRED, 0, 0, 0, 0},
    '{1, REG_LETTER_J, 1, CMD_CLEAR, 0, 0, 0, PRED, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_FILL, 1, 0, 0, PRED, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 9, 63, 1, PRED, 0, 0, 0, 0},
    // extreme codes, folding switched on over a loaded square
    '{1, REG_LETTER_I, 63, CMD_CLEAR, 0, 0, 0, PRED, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_ENCODE, 1, 63, 1, PRED, 0, 0, 0, 0},
    '{0, REG_LETTER_I, 0, CMD_KEY, 1, 4, 0, PRED, 0, 0, 0, 0}
  };

  // register settings used by the random phases
  localparam logic [CODE_W-1:0] SET_I [NSET] = '{0, 9, 63, 1, 63, 20, 0, 17};
  localparam logic [CODE_W-1:0] SET_J [NSET] = '{0, 10, 62, 63, 1, 20, 17, 0};

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           cmd;
  logic [CODE_W-1:0]    first_char;
  logic [CODE_W-1:0]    second_char;
  logic                 has_second;
  logic                 out_valid;
  logic                 out_stall;
  logic [CODE_W-1:0]    out_first;
  logic [CODE_W-1:0]    out_second;
  logic                 enciphered;
  logic                 placed;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CODE_W-1:0]    cfg_data;

  playfair_digram_cipher uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .first_char(first_char), .second_char(second_char),
    .has_second(has_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first(out_first), .out_second(out_second),
    .enciphered(enciphered), .placed(placed),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the square and the registers
  logic [CODE_W-1:0] sq_cell [CELLS];
  logic [4:0]        cell_of [SYMBOLS];
  logic              present [SYMBOLS];
  int                fill_cnt = 0;
  logic [CODE_W-1:0] reg_i = '0;
  logic [CODE_W-1:0] reg_j = '0;

  result_t pending_cipher_out [$];
  int      sent_cnt = 0;
  int      errors = 0;
  int      enc_seen = 0;
  int      plc_seen = 0;
  int      phases = 0;
  int      reg_writes = 0;
  int      idle_cycles = 0;
  logic    held_off = 1'b0;

  // both sides run without idling in this window
  function automatic logic calm();
    return sent_cnt >= 1000 && sent_cnt < 1250;
  endfunction

  function automatic logic folds_to_i(input logic [CODE_W-1:0] c);
    return reg_i != '0 && reg_j != '0 && reg_i != reg_j && c == reg_j;
  endfunction

  function automatic logic place_letter(input logic [CODE_W-1:0] c);
    if (c == '0 || fill_cnt >= CELLS || present[c]) return 1'b0;
    present[c] = 1'b1;
    cell_of[c] = 5'(fill_cnt);
    sq_cell[fill_cnt] = c;
    fill_cnt++;
    return 1'b1;
  endfunction

  function automatic logic find_cell(input logic [CODE_W-1:0] c, output int pos);
    logic [CODE_W-1:0] k;
    k = folds_to_i(c) ? reg_i : c;
    pos = 0;
    if (k == '0 || !present[k]) return 1'b0;
    pos = int'(cell_of[k]);
    return 1'b1;
  endfunction

  function automatic void clear_square();
    for (int n = 0; n < SYMBOLS; n++) begin
      present[n] = 1'b0;
      cell_of[n] = '0;
    end
    for (int n = 0; n < CELLS; n++) sq_cell[n] = '0;
    fill_cnt = 0;
  endfunction

  // next square state and the result word for one input word
  function automatic result_t playfair_step(input word_t w);
    result_t r;
    int p0, p1, r0, c0, r1, c1, t0, t1;
    r = '0;
    case (w.op)
      CMD_CLEAR: clear_square();
      CMD_KEY: r.plc = place_letter(folds_to_i(w.a) ? reg_i : w.a);
      CMD_FILL: begin
        if (!folds_to_i(w.a)) r.plc = place_letter(w.a);
      end
      default: begin
        r.o1 = w.a;
        if (w.pair) begin
          r.o2 = w.b;
          if (find_cell(w.a, p0) && find_cell(w.b, p1) && p0 != p1) begin
            r0 = p0 / SIDE; c0 = p0 % SIDE;
            r1 = p1 / SIDE; c1 = p1 % SIDE;
            if (r0 == r1) begin
              t0 = r0 * SIDE + (c0 + 1) % SIDE;
              t1 = r1 * SIDE + (c1 + 1) % SIDE;
            end else if (c0 == c1) begin
              t0 = ((r0 + 1) % SIDE) * SIDE + c0;
              t1 = ((r1 + 1) % SIDE) * SIDE + c1;
            end else begin
              t0 = r0 * SIDE + c1;
              t1 = r1 * SIDE + c0;
            end
            if (sq_cell[t0] != '0 && sq_cell[t1] != '0) begin
              r.o1 = sq_cell[t0];
              r.o2 = sq_cell[t1];
              r.enc = 1'b1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // mostly letters in the square, sometimes i, j or any code
  function automatic logic [CODE_W-1:0] pick_letter();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70 && fill_cnt > 0) return sq_cell[$urandom_range(0, fill_cnt - 1)];
    if (roll < 78) return reg_j;
    if (roll < 84) return reg_i;
    return CODE_W'($urandom_range(0, 63));
  endfunction

  // offer one word until accepted, then queue its expected result
  task automatic send_word(input cmd_t op, input logic [CODE_W-1:0] a,
                           input logic [CODE_W-1:0] b, input logic pair,
                           input logic typed, input result_t want);
    word_t   w;
    result_t r;
    w = '{op, a, b, pair};
    if (!calm() && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    first_char  <= a;
    second_char <= b;
    has_second  <= pair;
    do @(posedge clk); while (in_stall);
    r = playfair_step(w);
    pending_cipher_out.push_back(typed ? want : r);
    sent_cnt++;
  endtask

  // register write once every result is out
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_cipher_out.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_LETTER_I) reg_i = val;
    else reg_j = val;
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // stimulus
  initial begin
    int      order [63];
    int      k, j, tmp, nkey, nfill, nenc, over;
    logic    only_one;
    cmd_t    op;
    result_t want;

    rst         <= 1'b1;
    in_valid    <= 1'b0;
    cmd         <= CMD_CLEAR;
    first_char  <= '0;
    second_char <= '0;
    has_second  <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_LETTER_I;
    cfg_data    <= '0;
    clear_square();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int n = 0; n < NDIR; n++) begin
      if (DIRECTED[n].wr) begin
        write_reg(DIRECTED[n].ridx, DIRECTED[n].rval);
      end else begin
        want = '{DIRECTED[n].o1, DIRECTED[n].o2, DIRECTED[n].enc, DIRECTED[n].plc};
        send_word(DIRECTED[n].op, DIRECTED[n].a, DIRECTED[n].b, DIRECTED[n].pair,
                  DIRECTED[n].typed, want);
      end
    end

    // random phases
    while (sent_cnt < ITEMS) begin
      phases++;
      k = $urandom_range(0, NSET);
      only_one = ($urandom_range(0, 3) == 0);
      if (k == NSET) begin
        if (!only_one || $urandom_range(0, 1)) write_reg(REG_LETTER_I, 6'($urandom_range(0, 63)));
        else write_reg(REG_LETTER_J, 6'($urandom_range(0, 63)));
        if (!only_one) write_reg(REG_LETTER_J, 6'($urandom_range(0, 63)));
      end else begin
        if (!only_one || $urandom_range(0, 1)) write_reg(REG_LETTER_I, SET_I[k]);
        else write_reg(REG_LETTER_J, SET_J[k]);
        if (!only_one) write_reg(REG_LETTER_J, SET_J[k]);
      end

      if ($urandom_range(0, 4) != 0) begin
        // well-formed: an optional clear, then keyword, fill and pairs
        if ($urandom_range(0, 3) != 0)
          send_word(CMD_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)), PRED, '0);
        nkey = $urandom_range(0, 8);
        for (int n = 0; n < nkey; n++) begin
          tmp = $urandom_range(0, 9);
          send_word(CMD_KEY, (tmp == 0) ? reg_j : (tmp == 1) ? reg_i : 6'($urandom_range(0, 63)),
                    6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), PRED, '0);
        end
        for (int n = 0; n < 63; n++) order[n] = n + 1;
        for (int n = 62; n > 0; n--) begin
          j = $urandom_range(0, n);
          tmp = order[n];
          order[n] = order[j];
          order[j] = tmp;
        end
        nfill = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 24) : 63;
        over = 0;
        for (int n = 0; n < nfill; n++) begin
          send_word(CMD_FILL, 6'(order[n]), 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)), PRED, '0);
          if (fill_cnt == CELLS) over++;
          if (over > 3) break;
        end
        nenc = $urandom_range(15, 40);
        for (int n = 0; n < nenc; n++)
          send_word(CMD_ENCODE, pick_letter(), pick_letter(),
                    ($urandom_range(0, 99) < 92), PRED, '0);
      end else begin
        // noise: any command with any fields
        for (int n = 0; n < 30; n++) begin
          op = ($urandom_range(0, 9) == 0) ? CMD_CLEAR : cmd_t'($urandom_range(1, 3));
          send_word(op, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)), PRED, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_cipher_out.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("%0d words in %0d phases, %0d register writes, one long output hold-off",
             sent_cnt, phases, reg_writes);
    $display("%0d pairs enciphered, %0d characters placed, %0d mismatches",
             enc_seen, plc_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin
    out_stall <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_off && sent_cnt >= 400) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm() && ($urandom_range(0, 99) < 35);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cipher_out.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %0d %0d %0d %0d",
                 $time, out_first, out_second, enciphered, placed);
        errors++;
      end else begin
        want = pending_cipher_out.pop_front();
        check_field("out_first", want.o1, out_first);
        check_field("out_second", want.o2, out_second);
        check_field("enciphered", want.enc, enciphered);
        check_field("placed", want.plc, placed);
      end
      if (enciphered) enc_seen++;
      if (placed) plc_seen++;
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### playfair_digram_cipher.f
+incdir+src
src/pdc_pkg.sv
src/pdc_ram.sv
src/pdc_ctrl.sv
src/pdc_dpath.sv
src/playfair_digram_cipher.sv
sim/tb_top.sv
